// ===== hw/rtl/pcss_pkg.sv =====
// Package for the cathode PWM serial scanner.
// Holds field widths, default parameter values, op codes and the state type.
// No dependencies.
package pcss_pkg;

    localparam int TUBES_DEF           = 6;
    localparam int DIGITS_PER_TUBE_DEF = 10;
    localparam int COLONS_DEF          = 4;
    localparam int BRIGHT_LEVELS_DEF   = 16;

    localparam int OP_W       = 2;
    localparam int TUBE_W     = 3;
    localparam int DIGIT_W    = 4;
    localparam int COLON_W    = 3;
    localparam int VALUE_W    = 8;
    localparam int TIME_W     = 32;
    localparam int BIDX_W     = 6;
    localparam int LAMPS_W    = 8;
    localparam int POS_W      = 6;
    localparam int VEC_W      = 64;
    // wide enough for tube * digits + digit at the largest parameter values
    localparam int IDX_FULL_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_SET_LEVEL  = 2'd0,
        OP_SET_POS    = 2'd1,
        OP_SET_COLON  = 2'd2,
        OP_TICK       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PHASE,
        ST_SCAN,
        ST_SHIFT
    } t_state;

endpackage

// ===== hw/rtl/pwm_cathode_serial_scanner_core.sv =====
// Top level of the cathode PWM serial scanner.
// Depends on pcss_pkg.
//
// Write items give no output. A tick runs the bit-serial phase (time modulo
// levels), then scans the level and position memories one cathode a cycle,
// then shifts out one output bit per cycle (up to 64) while the sink is
// ready. One item in flight at a time. Synchronous active-low reset restores
// all cathode levels and bit positions at once through per-entry valid bits
// and resets the colon levels directly; no clearing pass.
module pwm_cathode_serial_scanner_core #(
    parameter int TUBES           = pcss_pkg::TUBES_DEF,
    parameter int DIGITS_PER_TUBE = pcss_pkg::DIGITS_PER_TUBE_DEF,
    parameter int COLONS          = pcss_pkg::COLONS_DEF,
    parameter int BRIGHT_LEVELS   = pcss_pkg::BRIGHT_LEVELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [pcss_pkg::OP_W-1:0]      i_op,
    input  logic [pcss_pkg::TUBE_W-1:0]    i_tube_index,
    input  logic [pcss_pkg::DIGIT_W-1:0]   i_digit_index,
    input  logic [pcss_pkg::COLON_W-1:0]   i_colon_index,
    input  logic [pcss_pkg::VALUE_W-1:0]   i_value,
    input  logic [pcss_pkg::TIME_W-1:0]    i_time_ms,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_serial_bit,
    output logic [pcss_pkg::BIDX_W-1:0]    o_bit_index,
    output logic                           o_last,
    output logic [pcss_pkg::LAMPS_W-1:0]   o_colon_lamps
);
    import pcss_pkg::*;

    localparam int ELEMENTS = TUBES * DIGITS_PER_TUBE;
    localparam int NBITS    = (ELEMENTS > VEC_W) ? VEC_W : ELEMENTS;
    localparam int ELEM_W   = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int CNT_W    = ($clog2(ELEMENTS + 1) > 6) ? $clog2(ELEMENTS + 1) : 6;
    localparam int COL_IW   = (COLONS > 1) ? $clog2(COLONS) : 1;
    localparam int PH_W     = $clog2(BRIGHT_LEVELS);
    localparam logic [VALUE_W-1:0] LEVEL_RST = VALUE_W'(BRIGHT_LEVELS);

    t_state r_state, n_state;

    // level and position memories, with reset-state valid bits
    logic [VALUE_W-1:0] r_lvl_mem [ELEMENTS];
    logic [POS_W-1:0]   r_pos_mem [ELEMENTS];
    logic [ELEMENTS-1:0] r_lvl_vld;
    logic [ELEMENTS-1:0] r_pos_vld;
    logic [VALUE_W-1:0] r_colon_lvl [COLONS];

    logic [VALUE_W-1:0] r_rd_lvl;
    logic [POS_W-1:0]   r_rd_pos;
    logic               r_rd_ok;

    logic [TIME_W-1:0]  r_time;
    logic [PH_W-1:0]    r_ph;
    logic [CNT_W-1:0]   r_cnt;
    logic [VEC_W-1:0]   r_vec;
    logic [BIDX_W-1:0]  r_bidx;

    logic                  w_in_acc;
    logic                  w_out_acc;
    logic [IDX_FULL_W-1:0] w_idx_sum;
    logic [ELEM_W-1:0]     w_wr_idx;
    logic                  w_cath_ok;
    logic                  w_colon_ok;
    logic                  w_rd_en;
    logic [ELEM_W-1:0]     w_rd_addr;
    logic [PH_W:0]         w_ph_trial;
    logic                  w_ph_ge;
    logic [PH_W-1:0]       w_ph_next;
    logic [VALUE_W-1:0]    w_phase8;
    logic [LAMPS_W-1:0]    w_lamps;
    logic                  w_phase_done;
    logic                  w_scan_done;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    assign w_idx_sum = IDX_FULL_W'(i_tube_index) * IDX_FULL_W'(DIGITS_PER_TUBE)
                     + IDX_FULL_W'(i_digit_index);
    assign w_wr_idx  = w_idx_sum[ELEM_W-1:0];
    assign w_cath_ok = ({1'b0, i_tube_index} < 4'(TUBES))
                    && (i_digit_index < DIGIT_W'(DIGITS_PER_TUBE));
    assign w_colon_ok = {1'b0, i_colon_index} < 4'(COLONS);

    assign w_rd_addr = r_cnt[ELEM_W-1:0];

    // one remainder digit per cycle: r = (2r + bit) mod levels
    assign w_ph_trial = {r_ph, r_time[TIME_W-1]};
    assign w_ph_ge    = 9'(w_ph_trial) >= 9'(BRIGHT_LEVELS);
    assign w_ph_next  = w_ph_ge ? PH_W'(9'(w_ph_trial) - 9'(BRIGHT_LEVELS))
                                : PH_W'(w_ph_trial);
    assign w_phase8   = VALUE_W'(r_ph);

    assign w_phase_done = r_cnt == CNT_W'(TIME_W - 1);
    assign w_scan_done  = r_cnt == CNT_W'(ELEMENTS);

    always_comb begin
        w_lamps = '0;
        for (int c = 0; c < COLONS; c++) begin
            w_lamps[c] = r_colon_lvl[c] > w_phase8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_valid = 1'b0;
        w_rd_en = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && t_op'(i_op) == OP_TICK) begin
                    n_state = ST_PHASE;
                end
            end
            ST_PHASE: begin
                if (w_phase_done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_rd_en = r_cnt < CNT_W'(ELEMENTS);
                if (w_scan_done) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                o_valid = 1'b1;
                if (i_ready && r_bidx == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memories: written from idle items, read during the scan
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_cath_ok && t_op'(i_op) == OP_SET_LEVEL) begin
            r_lvl_mem[w_wr_idx] <= i_value;
        end
        if (w_in_acc && w_cath_ok && t_op'(i_op) == OP_SET_POS) begin
            r_pos_mem[w_wr_idx] <= i_value[POS_W-1:0];
        end
        if (w_rd_en) begin
            r_rd_lvl <= r_lvl_vld[w_rd_addr] ? r_lvl_mem[w_rd_addr] : LEVEL_RST;
            r_rd_pos <= r_pos_vld[w_rd_addr] ? r_pos_mem[w_rd_addr]
                                             : POS_W'(w_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_vld <= '0;
            r_pos_vld <= '0;
            r_rd_ok   <= 1'b0;
            for (int c = 0; c < COLONS; c++) begin
                r_colon_lvl[c] <= LEVEL_RST;
            end
        end else begin
            r_rd_ok <= w_rd_en;
            if (w_in_acc && w_cath_ok && t_op'(i_op) == OP_SET_LEVEL) begin
                r_lvl_vld[w_wr_idx] <= 1'b1;
            end
            if (w_in_acc && w_cath_ok && t_op'(i_op) == OP_SET_POS) begin
                r_pos_vld[w_wr_idx] <= 1'b1;
            end
            if (w_in_acc && w_colon_ok && t_op'(i_op) == OP_SET_COLON) begin
                r_colon_lvl[i_colon_index[COL_IW-1:0]] <= i_value;
            end
        end
    end

    // datapath for the tick
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_time <= i_time_ms;
                r_ph   <= '0;
                r_cnt  <= '0;
            end
            ST_PHASE: begin
                r_time <= {r_time[TIME_W-2:0], 1'b0};
                r_ph   <= w_ph_next;
                r_cnt  <= w_phase_done ? '0 : r_cnt + 1'b1;
                r_vec  <= '1;
            end
            ST_SCAN: begin
                r_cnt <= r_cnt + 1'b1;
                // bits above NBITS-1 are shifted out unseen, so no range check
                if (r_rd_ok && r_rd_lvl > w_phase8) begin
                    r_vec[r_rd_pos] <= 1'b0;
                end
                r_bidx <= BIDX_W'(NBITS - 1);
            end
            ST_SHIFT: begin
                if (w_out_acc) begin
                    r_vec  <= {r_vec[VEC_W-2:0], 1'b1};
                    r_bidx <= r_bidx - 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_serial_bit  = r_vec[NBITS-1];
    assign o_bit_index   = r_bidx;
    assign o_last        = r_bidx == '0;
    assign o_colon_lamps = o_last ? w_lamps : '0;

endmodule

// ===== sim/tb_pwm_cathode_serial_scanner_core.sv =====
`timescale 1ns / 1ps
// Testbench for pwm_cathode_serial_scanner_core: directed and random items,
// with the shifted cathode bits and colon lamps predicted inside the bench.
// Depends on pcss_pkg and the core RTL.
module tb_pwm_cathode_serial_scanner_core;
    import pcss_pkg::*;

    localparam int NTUBES       = TUBES_DEF;
    localparam int NDIGITS      = DIGITS_PER_TUBE_DEF;
    localparam int NCOLONS      = COLONS_DEF;
    localparam int NLEVELS      = BRIGHT_LEVELS_DEF;
    localparam int NCATH        = NTUBES * NDIGITS;
    localparam int NBITS        = (NCATH > 64) ? 64 : NCATH;
    localparam int RANDOM_ITEMS = 235;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 600;

    typedef struct {
        t_op                  op;
        logic [TUBE_W-1:0]    tube;
        logic [DIGIT_W-1:0]   digit;
        logic [COLON_W-1:0]   colon;
        logic [VALUE_W-1:0]   value;
        logic [TIME_W-1:0]    time_ms;
    } t_cmd;

    typedef struct {
        logic                 sbit;
        logic [BIDX_W-1:0]    idx;
        logic                 last;
        logic [LAMPS_W-1:0]   lamps;
    } t_shift_bit;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic                   o_serial_bit;
    logic [BIDX_W-1:0]      o_bit_index;
    logic                   o_last;
    logic [LAMPS_W-1:0]     o_colon_lamps;

    t_cmd drv_cmd = '{OP_SET_LEVEL, '0, '0, '0, '0, '0};

    pwm_cathode_serial_scanner_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (drv_cmd.op),
        .i_tube_index  (drv_cmd.tube),
        .i_digit_index (drv_cmd.digit),
        .i_colon_index (drv_cmd.colon),
        .i_value       (drv_cmd.value),
        .i_time_ms     (drv_cmd.time_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_serial_bit  (o_serial_bit),
        .o_bit_index   (o_bit_index),
        .o_last        (o_last),
        .o_colon_lamps (o_colon_lamps)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // shadow copy of the display state
    logic [VALUE_W-1:0] lvl_mem   [NCATH];
    logic [POS_W-1:0]   pos_mem   [NCATH];
    logic [VALUE_W-1:0] colon_mem [NCOLONS];

    t_cmd        cmd_queue[$];
    t_shift_bit  pending_bits[$];
    int          fail_count = 0;
    int          bits_seen = 0;
    int unsigned cycles = 0;
    logic        took = 1'b0;

    // Update the shadow state, or for a tick queue the whole bit stream.
    task automatic apply_cmd(input t_cmd c);
        int unsigned idx;
        int unsigned phase;
        logic [VEC_W-1:0]   vec;
        logic [LAMPS_W-1:0] lamps;
        t_shift_bit b;
        case (c.op)
            OP_SET_LEVEL, OP_SET_POS: begin
                if (c.tube < NTUBES && c.digit < NDIGITS) begin
                    idx = c.tube * NDIGITS + c.digit;
                    if (c.op == OP_SET_LEVEL)
                        lvl_mem[idx] = c.value;
                    else
                        pos_mem[idx] = c.value[POS_W-1:0];
                end
            end
            OP_SET_COLON: begin
                if (c.colon < NCOLONS)
                    colon_mem[c.colon] = c.value;
            end
            default: begin
                phase = c.time_ms % NLEVELS;
                vec = '1;
                lamps = '0;
                for (int i = 0; i < NCATH; i++) begin
                    if (lvl_mem[i] > phase && pos_mem[i] < NBITS)
                        vec[pos_mem[i]] = 1'b0;
                end
                for (int i = 0; i < NCOLONS && i < LAMPS_W; i++) begin
                    if (colon_mem[i] > phase)
                        lamps[i] = 1'b1;
                end
                for (int p = NBITS - 1; p >= 0; p--) begin
                    b.sbit  = vec[p];
                    b.idx   = p[BIDX_W-1:0];
                    b.last  = (p == 0);
                    b.lamps = (p == 0) ? lamps : '0;
                    pending_bits.push_back(b);
                end
            end
        endcase
    endtask

    task automatic check_bit();
        t_shift_bit want;
        bits_seen++;
        if (pending_bits.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected bit, expected none got index %0d serial %0b", $time,
                     o_bit_index, o_serial_bit);
        end else begin
            want = pending_bits.pop_front();
            if (o_serial_bit !== want.sbit) begin
                fail_count++;
                $display("%0t: serial_bit (bit %0d) expected %0b got %0b", $time,
                         want.idx, want.sbit, o_serial_bit);
            end
            if (o_bit_index !== want.idx) begin
                fail_count++;
                $display("%0t: bit_index expected %0d got %0d", $time,
                         want.idx, o_bit_index);
            end
            if (o_last !== want.last) begin
                fail_count++;
                $display("%0t: last (bit %0d) expected %0b got %0b", $time,
                         want.idx, want.last, o_last);
            end
            if (o_colon_lamps !== want.lamps) begin
                fail_count++;
                $display("%0t: colon_lamps (bit %0d) expected %h got %h", $time,
                         want.idx, want.lamps, o_colon_lamps);
            end
        end
    endtask

    function automatic t_cmd mk_cmd(t_op op, int tube, int digit, int colon, int value,
                                    logic [TIME_W-1:0] tm);
        t_cmd c;
        c.op      = op;
        c.tube    = tube[TUBE_W-1:0];
        c.digit   = digit[DIGIT_W-1:0];
        c.colon   = colon[COLON_W-1:0];
        c.value   = value[VALUE_W-1:0];
        c.time_ms = tm;
        return c;
    endfunction

    // Mostly in-range writes and ticks; a slice of out-of-range indexes as noise.
    function automatic t_cmd rand_cmd();
        t_cmd c;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            c.op = OP_TICK;
        else if (sel < 60)
            c.op = OP_SET_LEVEL;
        else if (sel < 80)
            c.op = OP_SET_POS;
        else
            c.op = OP_SET_COLON;
        c.tube  = TUBE_W'(($urandom_range(0, 9) == 0) ? $urandom
                                                      : $urandom_range(0, NTUBES - 1));
        c.digit = DIGIT_W'(($urandom_range(0, 9) == 0) ? $urandom
                                                       : $urandom_range(0, NDIGITS - 1));
        c.colon = COLON_W'(($urandom_range(0, 9) == 0) ? $urandom
                                                       : $urandom_range(0, NCOLONS - 1));
        sel = $urandom_range(0, 9);
        if (c.op == OP_SET_POS)
            c.value = (sel < 7) ? VALUE_W'($urandom_range(0, NBITS - 1)) :
                      (sel < 8) ? VALUE_W'($urandom_range(NBITS, 63)) : VALUE_W'($urandom);
        else
            c.value = (sel == 0) ? VALUE_W'(0) :
                      (sel == 1) ? VALUE_W'($urandom) : VALUE_W'($urandom_range(0, NLEVELS));
        c.time_ms = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom;
        return c;
    endfunction

    // item acceptance, prediction and output checks
    always @(posedge i_clk) begin
        cycles++;
        took <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready)
                check_bit();
            if (i_valid && o_ready)
                apply_cmd(drv_cmd);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("[pwm_cathode_serial_scanner_core] ERROR");
            $finish;
        end
    end

    int burst_left = 0;
    int gap_left = 0;

    // sender: bursts of items with random gaps
    always @(negedge i_clk) begin : drive
        logic nv;
        nv = i_valid;
        if (i_rst_n && (!i_valid || took)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_queue.size() > 0) begin
                drv_cmd <= cmd_queue.pop_front();
                nv = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 20);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left = 0;
                        3:       gap_left = $urandom_range(20, 60);
                        default: gap_left = $urandom_range(1, 8);
                    endcase
                end else begin
                    burst_left--;
                end
            end
        end
        i_valid <= nv;
    end

    int rcv_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    logic held_once = 1'b0;

    // receiver: stall pattern changes every so often; one long hold-off
    always @(negedge i_clk) begin : sink
        logic nr;
        if (mode_left == 0) begin
            rcv_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (rcv_mode)
            0:       nr = 1'b1;
            1:       nr = 1'($urandom_range(0, 1));
            2:       nr = (mode_left % 4) != 0;
            default: nr = $urandom_range(0, 9) != 0;
        endcase
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (!held_once && bits_seen >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            nr = 1'b0;
        end
        i_ready <= nr;
    end

    initial begin : stim
        t_cmd c;
        int n_rand;
        n_rand = 0;
        for (int i = 0; i < NCATH; i++) begin
            lvl_mem[i] = NLEVELS[VALUE_W-1:0];
            pos_mem[i] = i[POS_W-1:0];
        end
        for (int i = 0; i < NCOLONS; i++)
            colon_mem[i] = NLEVELS[VALUE_W-1:0];

        // directed: reset state, level and position extremes, ignored writes
        cmd_queue.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_TICK, 7, 15, 7, 255, 32'hFFFF_FFFF));
        cmd_queue.push_back(mk_cmd(OP_SET_LEVEL, 0, 0, 0, 0, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_LEVEL, NTUBES - 1, NDIGITS - 1, 0, 255, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_LEVEL, 2, 3, 0, NLEVELS - 1, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_LEVEL, 1, 1, 0, 1, 32'd0));
        // position wider than 6 bits folds onto cathode 5's bit
        cmd_queue.push_back(mk_cmd(OP_SET_POS, 0, 1, 0, 8'hC5, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_POS, 3, 4, 0, 62, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_POS, 4, 0, 0, 63, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_POS, 1, 2, 0, NBITS - 1, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_COLON, 0, 0, 0, 0, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_COLON, 0, 0, NCOLONS - 1, 255, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_COLON, 0, 0, 1, 8, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_LEVEL, 6, 0, 0, 0, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_LEVEL, 7, 15, 0, 0, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_POS, 2, 10, 0, 0, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_COLON, 0, 0, 4, 0, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_SET_COLON, 0, 0, 7, 0, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 32'd15));
        cmd_queue.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 32'd16));
        cmd_queue.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 32'd8));
        cmd_queue.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 32'd7));
        // cathode 5 dark, cathode 1 still lit on the same bit
        cmd_queue.push_back(mk_cmd(OP_SET_LEVEL, 0, 5, 0, 0, 32'd0));
        cmd_queue.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 32'h8000_0003));

        while (n_rand < RANDOM_ITEMS) begin
            c = rand_cmd();
            cmd_queue.push_back(c);
            if (c.op == OP_TICK ||
                (c.op == OP_SET_COLON && c.colon < NCOLONS) ||
                (c.op != OP_SET_COLON && c.tube < NTUBES && c.digit < NDIGITS))
                n_rand++;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || i_valid)
            @(posedge i_clk);
        while (pending_bits.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("[pwm_cathode_serial_scanner_core] OK");
        else
            $display("[pwm_cathode_serial_scanner_core] ERROR");
        $finish;
    end

endmodule
